// ===== rtl/tlb_region_page_mapper_macros.svh =====
// Assertion macros for the region page mapper RTL (used by tlbrpm_dp).
// Needs signals named clock and reset in the module that uses them.
`ifndef TLB_REGION_PAGE_MAPPER_MACROS_SVH
`define TLB_REGION_PAGE_MAPPER_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define TLBRPM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define TLBRPM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TLBRPM_ASSERT_NOW(lbl, ante, cons, msg)
`define TLBRPM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/tlbrpm_pkg.sv =====
// Shared constants, types and helpers for the region page mapper.
// No dependencies.
`default_nettype none
package tlbrpm_pkg;

   localparam int TLB_ENTRIES   = 48;
   localparam int ADDR_WIDTH    = 32;
   localparam int EXT_W         = 33;   // address plus carry
   localparam int BYTES_W       = 32;
   localparam int ENTRY_W       = 7;
   localparam int INDEX_W       = 6;
   localparam int VPN2_W        = 19;
   localparam int PFN_W         = 24;
   localparam int CODE_W        = 3;
   localparam int STATUS_W      = 2;
   localparam int UPPER_W       = 4;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 7;
   localparam int MAX_RESULTS   = 64;
   localparam int RES_CNT_W     = 6;
   localparam int PAIR_MIN_LOG2 = 13;
   localparam int MAX_CODE      = 6;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_MISALIGNED = 2'd1,
      STATUS_TABLE_FULL = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_ENTRY = 2'd0,
      CSR_ENTRY_LIMIT = 2'd1,
      CSR_UPPER_ADDR  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic load;   // take the request into the datapath
      logic calc;   // work out one chunk into the result register
   } dp_cmd_type;

   typedef struct packed {
      logic empty;  // request on the port has zero length
      logic last;   // result register holds the final result
   } dp_status_type;

   // bytes covered by a page pair of size code c
   function automatic logic [EXT_W-1:0] pair_bytes(input int c);
      return EXT_W'(1) << (PAIR_MIN_LOG2 + 2 * c);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/tlbrpm_ctrl.sv =====
// Sequencer for the region page mapper: request intake, chunk steps, result hand-off.
// Depends on tlbrpm_pkg.
`default_nettype none
module tlbrpm_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   input  wire tlbrpm_pkg::dp_status_type  dp_status,
   output tlbrpm_pkg::dp_cmd_type          dp_cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;
   logic      rsp_valid_ff;

   always_comb begin
      state_in    = state_ff;
      dp_cmd.load = 1'b0;
      dp_cmd.calc = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = dp_status.empty ? S_IDLE : S_CALC;
            end
         end
         S_CALC: begin
            dp_cmd.calc = 1'b1;
            state_in    = S_OUT;
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = dp_status.last ? S_IDLE : S_CALC;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         req_stall_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != S_IDLE);
         rsp_valid_ff <= (state_in == S_OUT);
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== rtl/tlbrpm_dp.sv =====
// Datapath for the region page mapper: registers, entry counter, chunk sizing.
// Depends on tlbrpm_pkg and tlb_region_page_mapper_macros.svh.
`default_nettype none
`include "tlb_region_page_mapper_macros.svh"
module tlbrpm_dp (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire tlbrpm_pkg::dp_cmd_type                 dp_cmd,
   output tlbrpm_pkg::dp_status_type                   dp_status,
   input  wire logic                                   csr_write,
   input  wire logic [tlbrpm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tlbrpm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                                   req_restart,
   input  wire logic [31:0]                            req_phys_addr,
   input  wire logic [31:0]                            req_virt_addr,
   input  wire logic [tlbrpm_pkg::BYTES_W-1:0]         req_region_bytes,
   input  wire logic                                   req_writable,
   output logic [tlbrpm_pkg::INDEX_W-1:0]              rsp_entry_index,
   output logic [tlbrpm_pkg::VPN2_W-1:0]               rsp_vpn2,
   output logic [tlbrpm_pkg::PFN_W-1:0]                rsp_pfn_even,
   output logic [tlbrpm_pkg::PFN_W-1:0]                rsp_pfn_odd,
   output logic [tlbrpm_pkg::CODE_W-1:0]               rsp_page_size_code,
   output logic                                        rsp_dirty,
   output logic                                        rsp_last,
   output logic [tlbrpm_pkg::STATUS_W-1:0]             rsp_status
);

   localparam int AW = tlbrpm_pkg::ADDR_WIDTH;
   localparam int XW = tlbrpm_pkg::EXT_W;
   localparam int BW = tlbrpm_pkg::BYTES_W;
   localparam int EW = tlbrpm_pkg::ENTRY_W;

   // configuration
   logic [tlbrpm_pkg::INDEX_W-1:0] first_entry_ff, first_entry_in;
   logic [EW-1:0]                  entry_limit_ff, entry_limit_in;
   logic [tlbrpm_pkg::UPPER_W-1:0] upper_ff, upper_in;

   // working state
   logic [EW-1:0]                    next_entry_ff, next_entry_in;
   logic [AW-1:0]                    paddr_ff, paddr_in;
   logic [AW-1:0]                    vaddr_ff, vaddr_in;
   logic [BW-1:0]                    remain_ff, remain_in;
   logic                             dirty_ff, dirty_in;
   logic [tlbrpm_pkg::RES_CNT_W-1:0] count_ff, count_in;

   // result register
   logic [tlbrpm_pkg::INDEX_W-1:0]  out_index_ff, out_index_in;
   logic [tlbrpm_pkg::VPN2_W-1:0]   out_vpn2_ff, out_vpn2_in;
   logic [tlbrpm_pkg::PFN_W-1:0]    out_pfn_even_ff, out_pfn_even_in;
   logic [tlbrpm_pkg::PFN_W-1:0]    out_pfn_odd_ff, out_pfn_odd_in;
   logic [tlbrpm_pkg::CODE_W-1:0]   out_code_ff, out_code_in;
   logic                            out_dirty_ff, out_dirty_in;
   logic                            out_last_ff, out_last_in;
   tlbrpm_pkg::status_type          out_status_ff, out_status_in;

   // chunk sizing
   logic [XW-1:0]                 paddr_x, vaddr_x, remain_x;
   logic [XW-1:0]                 pair, odd_sum;
   logic [tlbrpm_pkg::CODE_W-1:0] code;
   logic                          found;
   logic [EW-1:0]                 limit_eff;
   logic                          table_full, misaligned, overflow;
   tlbrpm_pkg::status_type        chunk_status;
   logic [BW-1:0]                 remain_after;
   logic [tlbrpm_pkg::PFN_W-1:0]  upper_bits;

   assign paddr_x    = XW'(paddr_ff);
   assign vaddr_x    = XW'(vaddr_ff);
   assign remain_x   = XW'(remain_ff);
   assign upper_bits = {upper_ff, {(tlbrpm_pkg::PFN_W - tlbrpm_pkg::UPPER_W){1'b0}}};

   // largest aligned pair no more than 8K past the remaining bytes
   always_comb begin
      found = 1'b0;
      code  = '0;
      pair  = tlbrpm_pkg::pair_bytes(0);
      for (int c = tlbrpm_pkg::MAX_CODE; c >= 1; c--) begin
         if (!found
             && (tlbrpm_pkg::pair_bytes(c) - tlbrpm_pkg::pair_bytes(0)) <= remain_x
             && (paddr_x & (tlbrpm_pkg::pair_bytes(c) - XW'(1))) == '0) begin
            found = 1'b1;
            code  = tlbrpm_pkg::CODE_W'(c);
            pair  = tlbrpm_pkg::pair_bytes(c);
         end
      end
   end

   assign limit_eff  = (entry_limit_ff > EW'(tlbrpm_pkg::TLB_ENTRIES))
                       ? EW'(tlbrpm_pkg::TLB_ENTRIES) : entry_limit_ff;
   assign table_full = (next_entry_ff >= limit_eff);
   assign misaligned = (paddr_x[tlbrpm_pkg::PAIR_MIN_LOG2-1:0] != '0);
   // last result slot, and this chunk would leave bytes unmapped
   assign overflow   = (count_ff == tlbrpm_pkg::RES_CNT_W'(tlbrpm_pkg::MAX_RESULTS - 1))
                       && (pair < remain_x);
   assign odd_sum    = paddr_x + (pair >> 1);
   assign remain_after = (pair >= remain_x) ? '0 : BW'(remain_x - pair);

   always_comb begin
      if (table_full) begin
         chunk_status = tlbrpm_pkg::STATUS_TABLE_FULL;
      end else if (misaligned) begin
         chunk_status = tlbrpm_pkg::STATUS_MISALIGNED;
      end else if (overflow) begin
         chunk_status = tlbrpm_pkg::STATUS_TABLE_FULL;
      end else begin
         chunk_status = tlbrpm_pkg::STATUS_OK;
      end
   end

   // configuration writes; unknown indexes are ignored
   always_comb begin
      first_entry_in = first_entry_ff;
      entry_limit_in = entry_limit_ff;
      upper_in       = upper_ff;
      if (csr_write) begin
         case (csr_index)
            tlbrpm_pkg::CSR_FIRST_ENTRY: first_entry_in = csr_wdata[tlbrpm_pkg::INDEX_W-1:0];
            tlbrpm_pkg::CSR_ENTRY_LIMIT: entry_limit_in = csr_wdata[EW-1:0];
            tlbrpm_pkg::CSR_UPPER_ADDR:  upper_in = csr_wdata[tlbrpm_pkg::UPPER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      next_entry_in   = next_entry_ff;
      paddr_in        = paddr_ff;
      vaddr_in        = vaddr_ff;
      remain_in       = remain_ff;
      dirty_in        = dirty_ff;
      count_in        = count_ff;
      out_index_in    = out_index_ff;
      out_vpn2_in     = out_vpn2_ff;
      out_pfn_even_in = out_pfn_even_ff;
      out_pfn_odd_in  = out_pfn_odd_ff;
      out_code_in     = out_code_ff;
      out_dirty_in    = out_dirty_ff;
      out_last_in     = out_last_ff;
      out_status_in   = out_status_ff;
      if (dp_cmd.load) begin
         if (req_restart) begin
            next_entry_in = EW'(first_entry_ff);
         end
         paddr_in  = req_phys_addr[AW-1:0];
         vaddr_in  = req_virt_addr[AW-1:0];
         remain_in = req_region_bytes;
         dirty_in  = req_writable;
         count_in  = '0;
      end else if (dp_cmd.calc) begin
         out_index_in  = next_entry_ff[tlbrpm_pkg::INDEX_W-1:0];
         out_vpn2_in   = vaddr_x[31:13];
         out_dirty_in  = dirty_ff;
         out_status_in = chunk_status;
         if (chunk_status == tlbrpm_pkg::STATUS_OK) begin
            out_pfn_even_in = tlbrpm_pkg::PFN_W'(paddr_x[XW-1:12]) | upper_bits;
            out_pfn_odd_in  = tlbrpm_pkg::PFN_W'(odd_sum[XW-1:12]) | upper_bits;
            out_code_in     = code;
            out_last_in     = (remain_after == '0);
            next_entry_in   = next_entry_ff + EW'(1);
            paddr_in        = AW'(paddr_x + pair);
            vaddr_in        = AW'(vaddr_x + pair);
            remain_in       = remain_after;
            count_in        = count_ff + tlbrpm_pkg::RES_CNT_W'(1);
         end else begin
            out_pfn_even_in = '0;
            out_pfn_odd_in  = '0;
            out_code_in     = '0;
            out_last_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_entry_ff <= '0;
         entry_limit_ff <= EW'(48);
         upper_ff       <= '0;
         next_entry_ff  <= '0;
         out_last_ff    <= 1'b0;
      end else begin
         first_entry_ff <= first_entry_in;
         entry_limit_ff <= entry_limit_in;
         upper_ff       <= upper_in;
         next_entry_ff  <= next_entry_in;
         out_last_ff    <= out_last_in;
      end
   end

   always_ff @(posedge clock) begin
      paddr_ff        <= paddr_in;
      vaddr_ff        <= vaddr_in;
      remain_ff       <= remain_in;
      dirty_ff        <= dirty_in;
      count_ff        <= count_in;
      out_index_ff    <= out_index_in;
      out_vpn2_ff     <= out_vpn2_in;
      out_pfn_even_ff <= out_pfn_even_in;
      out_pfn_odd_ff  <= out_pfn_odd_in;
      out_code_ff     <= out_code_in;
      out_dirty_ff    <= out_dirty_in;
      out_status_ff   <= out_status_in;
   end

   assign dp_status.empty = (req_region_bytes == '0);
   assign dp_status.last  = out_last_ff;

   assign rsp_entry_index    = out_index_ff;
   assign rsp_vpn2           = out_vpn2_ff;
   assign rsp_pfn_even       = out_pfn_even_ff;
   assign rsp_pfn_odd        = out_pfn_odd_ff;
   assign rsp_page_size_code = out_code_ff;
   assign rsp_dirty          = out_dirty_ff;
   assign rsp_last           = out_last_ff;
   assign rsp_status         = out_status_ff;

   `TLBRPM_ASSERT_NEXT(a_entry_advance,
      !reset && dp_cmd.calc && chunk_status == tlbrpm_pkg::STATUS_OK,
      next_entry_ff == EW'($past(next_entry_ff) + EW'(1)),
      "entry counter did not advance on a mapped chunk")
   `TLBRPM_ASSERT_NEXT(a_error_final,
      !reset && dp_cmd.calc && chunk_status != tlbrpm_pkg::STATUS_OK,
      out_last_ff && out_pfn_even_ff == '0 && out_pfn_odd_ff == '0 && out_code_ff == '0,
      "error result not final or carries a mapping")
   `TLBRPM_ASSERT_NEXT(a_counter_hold,
      !reset && !dp_cmd.calc && !dp_cmd.load,
      $stable(next_entry_ff),
      "entry counter moved without a chunk or request")
   `TLBRPM_ASSERT_NOW(a_code_range,
      out_status_ff == tlbrpm_pkg::STATUS_OK,
      out_code_ff <= tlbrpm_pkg::CODE_W'(tlbrpm_pkg::MAX_CODE),
      "page size code out of range")

endmodule
`default_nettype wire

// ===== rtl/tlb_region_page_mapper.sv =====
// Top level of the region page mapper: sequencer plus datapath.
// Depends on tlbrpm_pkg, tlbrpm_ctrl and tlbrpm_dp.
//
// Usage:
//  - req_* carries one region request (restart, phys/virt address, length,
//    writable). It is taken when req_valid is high and req_stall low.
//  - Each request yields one rsp_* result per page-pair chunk, rsp_last on the
//    final one; an error (misaligned, table full) is one result with last set.
//    A zero-length request yields no result.
//  - Sequence: a taken request moves the sequencer to S_CALC, which sizes
//    the chunk into the result register, then to S_OUT, which raises
//    rsp_valid and waits there while rsp_stall is held. Each further chunk
//    repeats S_CALC and S_OUT, up to the 64-result cap. One request is
//    handled at a time: req_stall stays high until its last result is taken.
//  - rsp_stall high holds the result register and pauses the walk.
//  - csr_* writes first_entry (0), entry_limit (1) or upper_addr_bits (2);
//    csr_ready is always high. Write only while no request is in flight.
//  - Synchronous reset: sequencer idle, entry counter 0, first_entry 0,
//    entry_limit 48, upper_addr_bits 0.
`default_nettype none
module tlb_region_page_mapper (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // configuration port
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tlbrpm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [tlbrpm_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic                                req_restart,
   input  wire logic [31:0]                         req_phys_addr,
   input  wire logic [31:0]                         req_virt_addr,
   input  wire logic [31:0]                         req_region_bytes,
   input  wire logic                                req_writable,
   // result channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [5:0]                               rsp_entry_index,
   output logic [18:0]                              rsp_vpn2,
   output logic [23:0]                              rsp_pfn_even,
   output logic [23:0]                              rsp_pfn_odd,
   output logic [2:0]                               rsp_page_size_code,
   output logic                                     rsp_dirty,
   output logic                                     rsp_last,
   output logic [1:0]                               rsp_status
);

   tlbrpm_pkg::dp_cmd_type    dp_cmd;
   tlbrpm_pkg::dp_status_type dp_status;

   // registers live in flops, so a write can land any cycle
   assign csr_ready = 1'b1;

   tlbrpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   tlbrpm_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .dp_cmd             (dp_cmd),
      .dp_status          (dp_status),
      .csr_write          (csr_valid),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_restart        (req_restart),
      .req_phys_addr      (req_phys_addr),
      .req_virt_addr      (req_virt_addr),
      .req_region_bytes   (req_region_bytes),
      .req_writable       (req_writable),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_vpn2           (rsp_vpn2),
      .rsp_pfn_even       (rsp_pfn_even),
      .rsp_pfn_odd        (rsp_pfn_odd),
      .rsp_page_size_code (rsp_page_size_code),
      .rsp_dirty          (rsp_dirty),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status)
   );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for tlb_region_page_mapper: region requests in,
// page-pair TLB entries out, checked against an in-bench page splitter.
// Depends on tlbrpm_pkg and the tlb_region_page_mapper RTL.
module testbench;
   import tlbrpm_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;   // quiet cycles before giving up
   localparam int HOLD_CYCLES    = 150;    // long receiver hold-off
   localparam int DRAIN_CYCLES   = 16;     // settle time once nothing is due

   // one region request as seen on the req_ port
   typedef struct {
      bit        restart;
      bit [31:0] phys_addr;
      bit [31:0] virt_addr;
      bit [31:0] region_bytes;
      bit        writable;
   } region_req_t;

   // one TLB entry (or error) as seen on the rsp_ port; 4-state so X shows up
   typedef struct {
      logic [INDEX_W-1:0] entry_index;
      logic [VPN2_W-1:0]  vpn2;
      logic [PFN_W-1:0]   pfn_even;
      logic [PFN_W-1:0]   pfn_odd;
      logic [CODE_W-1:0]  page_size_code;
      logic               dirty;
      logic               last;
      status_type         status;
   } tlb_entry_t;

   // Splits each accepted region into the entries the block should emit and
   // checks the block's entries against them, oldest first.
   class region_split_tracker;
      bit [INDEX_W-1:0]  first_entry;
      bit [ENTRY_W-1:0]  entry_limit;
      bit [UPPER_W-1:0]  upper_bits;
      bit [ENTRY_W-1:0]  slot;          // shared entry counter
      tlb_entry_t        pending_entries[$];
      int unsigned       mismatches;

      function new();
         first_entry = '0;
         entry_limit = ENTRY_W'(TLB_ENTRIES);
         upper_bits  = '0;
         slot        = '0;
         mismatches  = 0;
      endfunction

      function void write_reg(csr_index_type idx, bit [CSR_DATA_W-1:0] value);
         case (idx)
            CSR_FIRST_ENTRY: first_entry = value[INDEX_W-1:0];
            CSR_ENTRY_LIMIT: entry_limit = value[ENTRY_W-1:0];
            CSR_UPPER_ADDR:  upper_bits  = value[UPPER_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_region(region_req_t r);
         bit [63:0]  amask, paddr, vaddr, remain, pair, span, lim, upper;
         bit [63:0]  pair_min;
         int         n;
         tlb_entry_t e;
         amask    = (64'd1 << ADDR_WIDTH) - 1;
         pair_min = 64'd1 << PAIR_MIN_LOG2;
         paddr    = r.phys_addr & amask;
         vaddr    = r.virt_addr & amask;
         remain   = r.region_bytes;
         upper    = 64'(upper_bits) << 20;
         n        = 0;
         if (r.restart)
            slot = ENTRY_W'(first_entry);
         lim = (entry_limit > TLB_ENTRIES) ? TLB_ENTRIES : entry_limit;
         while (remain != 0) begin
            // error fields by default; overwritten for a good chunk
            e.entry_index    = slot[INDEX_W-1:0];
            e.vpn2           = vaddr[31:13];
            e.pfn_even       = '0;
            e.pfn_odd        = '0;
            e.page_size_code = '0;
            e.dirty          = r.writable;
            e.last           = 1'b1;
            if (slot >= lim) begin
               e.status = STATUS_TABLE_FULL;
               pending_entries.push_back(e);
               break;
            end
            if ((paddr & (pair_min - 1)) != 0) begin
               e.status = STATUS_MISALIGNED;
               pending_entries.push_back(e);
               break;
            end
            e.page_size_code = '0;
            pair = pair_min;
            for (int c = MAX_CODE; c >= 1; c--) begin
               span = pair_min << (2 * c);
               if (span - pair_min <= remain && (paddr & (span - 1)) == 0) begin
                  e.page_size_code = CODE_W'(c);
                  pair = span;
                  break;
               end
            end
            if (n == MAX_RESULTS - 1 && pair < remain) begin
               e.page_size_code = '0;
               e.status = STATUS_TABLE_FULL;
               pending_entries.push_back(e);
               break;
            end
            // odd frame uses the unwrapped address of the upper half
            e.pfn_even = PFN_W'((paddr >> 12) | upper);
            e.pfn_odd  = PFN_W'(((paddr + (pair >> 1)) >> 12) | upper);
            remain     = (pair >= remain) ? 64'd0 : remain - pair;
            e.last     = (remain == 0);
            e.status   = STATUS_OK;
            pending_entries.push_back(e);
            n++;
            slot  = slot + 1'b1;
            paddr = (paddr + pair) & amask;
            vaddr = (vaddr + pair) & amask;
         end
      endfunction

      function void check_entry(tlb_entry_t got);
         tlb_entry_t want;
         if (pending_entries.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: entry with no request outstanding: idx %0d vpn2 %h st %0d",
                        $realtime, got.entry_index, got.vpn2, got.status);
            return;
         end
         want = pending_entries.pop_front();
         if (got.entry_index !== want.entry_index || got.vpn2 !== want.vpn2 ||
             got.pfn_even !== want.pfn_even || got.pfn_odd !== want.pfn_odd ||
             got.page_size_code !== want.page_size_code || got.dirty !== want.dirty ||
             got.last !== want.last || got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: entry mismatch", $realtime);
               $display("   exp idx %0d vpn2 %h pe %h po %h sz %0d d %b l %b st %0d",
                        want.entry_index, want.vpn2, want.pfn_even, want.pfn_odd,
                        want.page_size_code, want.dirty, want.last, want.status);
               $display("   got idx %0d vpn2 %h pe %h po %h sz %0d d %b l %b st %0d",
                        got.entry_index, got.vpn2, got.pfn_even, got.pfn_odd,
                        got.page_size_code, got.dirty, got.last, got.status);
            end
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   logic                  req_restart;
   logic [31:0]           req_phys_addr;
   logic [31:0]           req_virt_addr;
   logic [31:0]           req_region_bytes;
   logic                  req_writable;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [5:0]            rsp_entry_index;
   logic [18:0]           rsp_vpn2;
   logic [23:0]           rsp_pfn_even;
   logic [23:0]           rsp_pfn_odd;
   logic [2:0]            rsp_page_size_code;
   logic                  rsp_dirty;
   logic                  rsp_last;
   logic [1:0]            rsp_status;

   region_split_tracker tracker = new();

   bit calm;          // both sides run flat out while set
   bit pressure_due;  // asks the receiver for one long hold-off

   tlb_region_page_mapper uut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_restart        (req_restart),
      .req_phys_addr      (req_phys_addr),
      .req_virt_addr      (req_virt_addr),
      .req_region_bytes   (req_region_bytes),
      .req_writable       (req_writable),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_entry_index    (rsp_entry_index),
      .rsp_vpn2           (rsp_vpn2),
      .rsp_pfn_even       (rsp_pfn_even),
      .rsp_pfn_odd        (rsp_pfn_odd),
      .rsp_page_size_code (rsp_page_size_code),
      .rsp_dirty          (rsp_dirty),
      .rsp_last           (rsp_last),
      .rsp_status         (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one request and hold it until taken. Valid is left high on purpose:
   // the caller lowers it only when it decides to idle, so a back-to-back
   // request never sees valid dropped and raised in the same step.
   task automatic send_request(input region_req_t r);
      req_valid        <= 1'b1;
      req_restart      <= r.restart;
      req_phys_addr    <= r.phys_addr;
      req_virt_addr    <= r.virt_addr;
      req_region_bytes <= r.region_bytes;
      req_writable     <= r.writable;
      do @(posedge clock); while (req_stall);
      tracker.note_region(r);
   endtask

   task automatic send_region(input bit restart, input bit [31:0] phys, input bit [31:0] virt,
                              input bit [31:0] nbytes, input bit wr);
      region_req_t r;
      r.restart      = restart;
      r.phys_addr    = phys;
      r.virt_addr    = virt;
      r.region_bytes = nbytes;
      r.writable     = wr;
      send_request(r);
   endtask

   // Random sender gap of about a third of the cycles, none while calm.
   task automatic maybe_idle();
      if (!calm && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (!calm && $urandom_range(99) < 33);
      end
   endtask

   // Drain: wait until everything predicted has arrived, then let the
   // block settle before going on.
   task automatic wait_drained();
      while (tracker.pending_entries.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input bit [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, value);
   endtask

   task automatic program_regs(input bit [5:0] first, input bit [6:0] limit,
                               input bit [3:0] upper);
      csr_write(CSR_FIRST_ENTRY, CSR_DATA_W'(first));
      csr_write(CSR_ENTRY_LIMIT, CSR_DATA_W'(limit));
      csr_write(CSR_UPPER_ADDR,  CSR_DATA_W'(upper));
      csr_valid <= 1'b0;
   endtask

   // Random request: mostly aligned addresses at every alignment up to 64M,
   // some misaligned, lengths mostly small with a tail of huge ones that run
   // the table full.
   function automatic region_req_t random_region();
      region_req_t r;
      int unsigned align;
      int unsigned pick;
      r.restart   = ($urandom_range(99) < 35);
      r.virt_addr = $urandom;
      r.writable  = $urandom_range(1);
      if ($urandom_range(99) < 15) begin
         r.phys_addr = $urandom;
      end else begin
         align = $urandom_range(26, PAIR_MIN_LOG2);
         r.phys_addr = $urandom & ~((32'd1 << align) - 1);
      end
      pick = $urandom_range(99);
      if (pick < 4)
         r.region_bytes = 32'd0;
      else if (pick < 50)
         r.region_bytes = $urandom_range(32'h60000, 1);
      else if (pick < 75)
         r.region_bytes = $urandom_range(32'h500_0000, 1);
      else if (pick < 85)
         r.region_bytes = $urandom;
      else
         r.region_bytes = $urandom_range(128, 1) << PAIR_MIN_LOG2;
      return r;
   endfunction

   // Receiver: checks every entry taken and stalls at random, with one long
   // hold-off on request so the mapper backs up and stalls its input.
   initial begin
      int unsigned hold_left;
      tlb_entry_t  got;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            got.entry_index    = rsp_entry_index;
            got.vpn2           = rsp_vpn2;
            got.pfn_even       = rsp_pfn_even;
            got.pfn_odd        = rsp_pfn_odd;
            got.page_size_code = rsp_page_size_code;
            got.dirty          = rsp_dirty;
            got.last           = rsp_last;
            got.status         = status_type'(rsp_status);
            tracker.check_entry(got);
         end
         if (pressure_due) begin
            pressure_due = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (calm) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 33);
         end
      end
   end

   // Watchdog: any handshake on any channel counts as progress.
   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   // Main sequence: directed requests under reset settings, then phases of
   // random requests, each under its own register settings.
   initial begin
      int          items;
      int          sent;
      region_req_t r;
      calm             = 1'b0;
      pressure_due     = 1'b0;
      reset            = 1'b1;
      csr_valid        = 1'b0;
      csr_index        = CSR_FIRST_ENTRY;
      csr_wdata        = '0;
      req_valid        = 1'b0;
      req_restart      = 1'b0;
      req_phys_addr    = '0;
      req_virt_addr    = '0;
      req_region_bytes = '0;
      req_writable     = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty region, overshoot, exact fit, one of each page size
      send_region(1'b1, 32'h0000_0000, 32'h0000_0000, 32'd0,          1'b0);
      send_region(1'b1, 32'h0000_0000, 32'h0040_0000, 32'd1,          1'b1);
      send_region(1'b0, 32'h0000_2000, 32'h0040_2000, 32'h0000_2000,  1'b0);
      send_region(1'b0, 32'h0000_4000, 32'h1000_0000, 32'h0000_2001,  1'b1);
      send_region(1'b1, 32'h0200_0000, 32'h8000_0000, 32'h0200_0000,  1'b1);
      send_region(1'b0, 32'h0400_0000, 32'h8200_0000, 32'h01FF_E000,  1'b0);
      send_region(1'b0, 32'h0080_0000, 32'h1234_0000, 32'h0080_0000,  1'b1);
      send_region(1'b0, 32'h0020_0000, 32'h2000_0000, 32'h0020_0000,  1'b0);
      send_region(1'b0, 32'h0008_0000, 32'h3000_0000, 32'h0008_0000,  1'b1);
      send_region(1'b0, 32'h0002_0000, 32'h4000_0000, 32'h0002_0000,  1'b0);
      send_region(1'b0, 32'h0000_8000, 32'h5000_0000, 32'h0000_8000,  1'b1);
      send_region(1'b1, 32'h01FF_E000, 32'h6000_0000, 32'h0200_0000,  1'b1);
      // misaligned start, and a misaligned empty region that maps nothing
      send_region(1'b0, 32'h0000_1001, 32'h7000_0000, 32'h0000_4000,  1'b0);
      send_region(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  1'b1);
      send_region(1'b0, 32'h0000_0800, 32'h0000_0000, 32'd0,          1'b1);
      // address wrap at the top, then the table runs full
      send_region(1'b1, 32'hFFFF_E000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,  1'b1);
      // counter already at the limit: straight to table full
      send_region(1'b0, 32'h0000_0000, 32'h0000_0000, 32'h0000_2000,  1'b0);
      send_region(1'b1, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,  1'b0);
      send_region(1'b1, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000,  1'b1);
      req_valid <= 1'b0;
      wait_drained();

      for (int phase = 1; phase <= 6; phase++) begin
         case (phase)
            1: program_regs(6'd0, 7'd64, 4'd15);
            2: program_regs(6'd63, 7'd64, 4'd0);
            3: program_regs(6'd5, 7'd48, 4'd8);
            4: program_regs(6'($urandom_range(63)), 7'($urandom_range(64, 1)),
                            4'($urandom_range(15)));
            5: program_regs(6'd0, 7'd1, 4'd5);
            default: program_regs(6'd20, 7'd40, 4'd10);
         endcase
         // start-slot 63 is always past the limit, so that phase is kept short
         items = (phase == 2) ? 20 : 80;
         calm  = (phase == 3);
         if (phase == 4)
            pressure_due = 1'b1;
         sent = 0;
         while (sent < items) begin
            r = random_region();
            send_request(r);
            if (r.region_bytes != 0)
               sent++;
            maybe_idle();
         end
         req_valid <= 1'b0;
         calm = 1'b0;
         wait_drained();
      end

      while (tracker.pending_entries.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_entries.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== tlb_region_page_mapper.f =====
+incdir+rtl
rtl/tlbrpm_pkg.sv
rtl/tlbrpm_ctrl.sv
rtl/tlbrpm_dp.sv
rtl/tlb_region_page_mapper.sv
tb/testbench.sv
